// ----- hw/rtl/ips_pkg.sv -----
// ----------------------------------------------------------------------------
// Interrupt pulse sequencer package
// Shared types, item codes and phase codes of the interrupt pulse sequencer.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned OpW    = 2;
  localparam int unsigned PolW   = 2;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TimeW-1:0] TimeMax      = {TimeW{1'b1}};
  localparam logic [TimeW-1:0] IdleTimeRst  = TimeW'(2);
  localparam logic [TimeW-1:0] PulseTimeRst = TimeW'(2);

  localparam logic [OpW-1:0] OpTick    = 2'd0;
  localparam logic [OpW-1:0] OpRegister = 2'd1;
  localparam logic [OpW-1:0] OpCommand = 2'd2;

  localparam logic [PolW-1:0] PolRising  = 2'd0;
  localparam logic [PolW-1:0] PolFalling = 2'd1;
  localparam logic [PolW-1:0] PolNone    = 2'd2;

  localparam logic [CmdW-1:0] CmdCancel = 2'd0;
  localparam logic [CmdW-1:0] CmdInit   = 2'd1;
  localparam logic [CmdW-1:0] CmdStart  = 2'd2;
  localparam logic [CmdW-1:0] CmdDeinit = 2'd3;

  localparam logic [PhaseW-1:0] PhWaitReg = 3'd0;
  localparam logic [PhaseW-1:0] PhInit    = 3'd1;
  localparam logic [PhaseW-1:0] PhWait    = 3'd2;
  localparam logic [PhaseW-1:0] PhSetup   = 3'd3;
  localparam logic [PhaseW-1:0] PhHold    = 3'd4;
  localparam logic [PhaseW-1:0] PhDeinit  = 3'd5;

  localparam logic [CfgIdxW-1:0] CfgIdleTime  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPulseTime = 1'd1;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TimeW-1:0] elapsed_time;
    logic [PolW-1:0]  polarity_code;
    logic             driver_present;
    logic [CmdW-1:0]  command_code;
  } ips_in_t;

  typedef struct packed {
    logic              accepted;
    logic              line_write;
    logic              line_level;
    logic [PhaseW-1:0] phase_code;
  } ips_out_t;

  typedef struct packed {
    logic [TimeW-1:0] idle_time_needed;
    logic [TimeW-1:0] pulse_time_needed;
  } ips_cfg_t;

endpackage

// ----- hw/rtl/ips_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Interrupt pulse sequencer configuration registers
// Holds the minimum idle time and the minimum pulse time.
// ----------------------------------------------------------------------------
module ips_cfg_regs import ips_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_wdata_i,
  output ips_cfg_t           cfg_o
);

  ips_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdleTime:  cfg_d.idle_time_needed  = cfg_wdata_i;
        CfgPulseTime: cfg_d.pulse_time_needed = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_time_needed  <= IdleTimeRst;
      cfg_q.pulse_time_needed <= PulseTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/ips_core.sv -----
// ----------------------------------------------------------------------------
// Interrupt pulse sequencer core
// Sequencer state and the step logic that turns one item into one result.
// ----------------------------------------------------------------------------
module ips_core import ips_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  ips_in_t  item_i,
  input  ips_cfg_t cfg_i,
  output ips_out_t result_o
);

  logic [PhaseW-1:0] phase_d, phase_q;
  logic [PolW-1:0]   pol_d, pol_q;
  logic              drv_d, drv_q;
  logic [CmdW-1:0]   cmd_d, cmd_q;
  logic [TimeW-1:0]  at_d, at_q;
  logic [TimeW-1:0]  dt_d, dt_q;
  logic              idle_lvl;
  logic [TimeW-1:0]  dt_sat, at_sat, dt_grd, at_grd;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  assign idle_lvl = (pol_q == PolRising) ? 1'b0 : 1'b1;
  assign dt_sat   = sat_add(dt_q, item_i.elapsed_time);
  assign at_sat   = sat_add(at_q, item_i.elapsed_time);
  assign dt_grd   = (dt_q < cfg_i.idle_time_needed) ? dt_sat : cfg_i.idle_time_needed;
  assign at_grd   = (at_q < cfg_i.pulse_time_needed) ? at_sat : cfg_i.pulse_time_needed;

  always_comb begin
    phase_d = phase_q;
    pol_d   = pol_q;
    drv_d   = drv_q;
    cmd_d   = cmd_q;
    at_d    = at_q;
    dt_d    = dt_q;
    result_o.accepted   = 1'b0;
    result_o.line_write = 1'b0;
    result_o.line_level = 1'b0;
    case (item_i.op)
      OpRegister: begin
        if (item_i.driver_present &&
            (item_i.polarity_code == PolRising || item_i.polarity_code == PolFalling) &&
            phase_q == PhWaitReg) begin
          drv_d = 1'b1;
          pol_d = item_i.polarity_code;
          result_o.accepted = 1'b1;
        end
      end
      OpCommand: begin
        if (drv_q && pol_q != PolNone) begin
          cmd_d = item_i.command_code;
          result_o.accepted = 1'b1;
        end
      end
      OpTick: begin
        result_o.accepted = 1'b1;
        case (phase_q)
          PhWaitReg: begin
            if (cmd_q == CmdInit) phase_d = PhInit;
          end
          PhInit: begin
            result_o.line_write = 1'b1;
            result_o.line_level = idle_lvl;
            dt_d    = dt_grd;
            phase_d = PhWait;
          end
          PhWait: begin
            result_o.line_write = 1'b1;
            result_o.line_level = idle_lvl;
            dt_d = dt_grd;
            if (cmd_q == CmdStart) begin
              phase_d = PhSetup;
            end else if (cmd_q == CmdDeinit) begin
              phase_d = PhDeinit;
            end
          end
          PhSetup: begin
            if (cmd_q == CmdCancel) begin
              phase_d = PhWait;
              dt_d    = '0;
            end else if (dt_q < cfg_i.idle_time_needed) begin
              dt_d = dt_sat;
            end else begin
              result_o.line_write = 1'b1;
              result_o.line_level = ~idle_lvl;
              dt_d    = '0;
              at_d    = at_grd;
              phase_d = PhHold;
            end
          end
          PhHold: begin
            if (at_q < cfg_i.pulse_time_needed) begin
              at_d = at_sat;
            end else begin
              result_o.line_write = 1'b1;
              result_o.line_level = idle_lvl;
              cmd_d   = CmdCancel;
              phase_d = PhWait;
              at_d    = '0;
              dt_d    = dt_grd;
            end
          end
          PhDeinit: begin
            result_o.line_write = 1'b1;
            result_o.line_level = 1'b0;
            drv_d   = 1'b0;
            pol_d   = PolNone;
            phase_d = PhWaitReg;
            at_d    = '0;
            dt_d    = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    result_o.phase_code = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWaitReg;
      pol_q   <= PolNone;
      drv_q   <= 1'b0;
      cmd_q   <= CmdCancel;
      at_q    <= '0;
      dt_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pol_q   <= pol_d;
      drv_q   <= drv_d;
      cmd_q   <= cmd_d;
      at_q    <= at_d;
      dt_q    <= dt_d;
    end
  end

endmodule

// ----- hw/rtl/interrupt_pulse_sequencer.sv -----
// ----------------------------------------------------------------------------
// Interrupt pulse sequencer
// Drives an interrupt line as a timed pulse from ticks, register requests and
// commands, one result per input item.
// ----------------------------------------------------------------------------
// Results: each item is held in the input register; the step logic writes its
// result to the result register when that register is free or being taken.
// Throughput: one item per cycle while results are taken; a held result stalls
// the step logic, which updates the state once per item.
// Reset: asynchronous, active low; clears the sequencer state and sets both
// minimum times to 2. Configuration writes are taken in every cycle.
module interrupt_pulse_sequencer import ips_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ips_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ips_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_wdata_i
);

  ips_in_t  in_q;
  logic     in_vld_q;
  ips_out_t out_q;
  ips_out_t result;
  logic     out_vld_q;
  logic     step;
  ips_cfg_t cfg;

  assign step        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || step;
  assign cfg_ready_o = 1'b1;

  ips_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ips_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (step) out_q <= result;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/ips_checker.sv -----
// ----------------------------------------------------------------------------
// Interrupt pulse sequencer checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ips_checker import ips_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ips_out_t           out_data_o
);

  // The input side stalls only behind a result that is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  // Every input transfer is followed by a valid result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result after an input transfer");

  // Deinit always releases the line low.
  a_deinit_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_write && out_data_o.phase_code == PhWaitReg
    |-> !out_data_o.line_level)
    else $error("deinit drove the line high");

  // A result held back keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");

endmodule

bind interrupt_pulse_sequencer ips_checker u_ips_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interrupt pulse sequencer testbench
// Sends ticks, register requests and commands over the input channel and
// checks each result against an in-bench prediction of the line sequencing.
// A directed part covers refused requests and one full pulse with a cancel.
// Random rounds then run pulse sequences and raw noise under several
// minimum-time settings, with random idle bursts on both channels in all but the last.
// ----------------------------------------------------------------------------
module tb_top;
  import ips_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ips_in_t            in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ips_out_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TimeW-1:0]   cfg_wdata;

  logic [PhaseW-1:0]  ph;
  logic [PolW-1:0]    pol_reg;
  logic               drv_seen;
  logic [CmdW-1:0]    cmd_latched;
  logic [TimeW-1:0]   on_time;
  logic [TimeW-1:0]   off_time;
  logic [TimeW-1:0]   min_off;
  logic [TimeW-1:0]   min_on;

  ips_out_t line_actions_q[$];
  int       fails = 0;
  int       items_sent = 0;
  bit       idle_on = 1'b1;
  int       rx_hold = 0;

  interrupt_pulse_sequencer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] guarded_add(logic [TimeW-1:0] t, logic [TimeW-1:0] e,
                                                   logic [TimeW-1:0] limit);
    return (t < limit) ? sat_add(t, e) : limit;
  endfunction

  function automatic ips_out_t next_line_action(ips_in_t it);
    ips_out_t r;
    logic     idle_lvl;
    r = '0;
    idle_lvl = (pol_reg == PolRising) ? 1'b0 : 1'b1;
    case (it.op)
      OpRegister: begin
        if (it.driver_present && (it.polarity_code == PolRising ||
            it.polarity_code == PolFalling) && ph == PhWaitReg) begin
          drv_seen = 1'b1;
          pol_reg = it.polarity_code;
          r.accepted = 1'b1;
        end
      end
      OpCommand: begin
        if (drv_seen && pol_reg != PolNone) begin
          cmd_latched = it.command_code;
          r.accepted = 1'b1;
        end
      end
      OpTick: begin
        r.accepted = 1'b1;
        case (ph)
          PhWaitReg: begin
            if (cmd_latched == CmdInit) ph = PhInit;
          end
          PhInit: begin
            r.line_write = 1'b1;
            r.line_level = idle_lvl;
            off_time = guarded_add(off_time, it.elapsed_time, min_off);
            ph = PhWait;
          end
          PhWait: begin
            r.line_write = 1'b1;
            r.line_level = idle_lvl;
            off_time = guarded_add(off_time, it.elapsed_time, min_off);
            if (cmd_latched == CmdStart) ph = PhSetup;
            else if (cmd_latched == CmdDeinit) ph = PhDeinit;
          end
          PhSetup: begin
            if (cmd_latched == CmdCancel) begin
              ph = PhWait;
              off_time = '0;
            end else if (off_time < min_off) begin
              off_time = sat_add(off_time, it.elapsed_time);
            end else begin
              r.line_write = 1'b1;
              r.line_level = ~idle_lvl;
              off_time = '0;
              on_time = guarded_add(on_time, it.elapsed_time, min_on);
              ph = PhHold;
            end
          end
          PhHold: begin
            if (on_time < min_on) begin
              on_time = sat_add(on_time, it.elapsed_time);
            end else begin
              r.line_write = 1'b1;
              r.line_level = idle_lvl;
              cmd_latched = CmdCancel;
              ph = PhWait;
              on_time = '0;
              off_time = guarded_add(off_time, it.elapsed_time, min_off);
            end
          end
          PhDeinit: begin
            r.line_write = 1'b1;
            r.line_level = 1'b0;
            drv_seen = 1'b0;
            pol_reg = PolNone;
            ph = PhWaitReg;
            on_time = '0;
            off_time = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.phase_code = ph;
    return r;
  endfunction

  function automatic ips_in_t noise_item();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(ips_in_t)-1:0];
  endfunction

  function automatic ips_in_t tick_item(logic [TimeW-1:0] e);
    ips_in_t r;
    r = noise_item();
    r.op = OpTick;
    r.elapsed_time = e;
    return r;
  endfunction

  function automatic ips_in_t reg_item(logic [PolW-1:0] pol, logic drv);
    ips_in_t r;
    r = noise_item();
    r.op = OpRegister;
    r.polarity_code = pol;
    r.driver_present = drv;
    return r;
  endfunction

  function automatic ips_in_t cmd_item(logic [CmdW-1:0] cmd);
    ips_in_t r;
    r = noise_item();
    r.op = OpCommand;
    r.command_code = cmd;
    return r;
  endfunction

  function automatic logic [TimeW-1:0] rand_elapsed();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return TimeW'(raw[1:0]);
      5, 6, 7: return raw[TimeW-1:0];
      8: return TimeMax;
      default: return {1'b1, raw[TimeW-2:0]};
    endcase
  endfunction

  function automatic logic [TimeW-1:0] rand_min_time();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return TimeW'($urandom_range(0, 6));
      6: return '0;
      7: return TimeMax;
      default: return raw[TimeW-1:0];
    endcase
  endfunction

  task automatic send_item(ips_in_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    line_actions_q.push_back(next_line_action(item));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    while (line_actions_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_min_time(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgIdleTime) min_off = value;
    else min_on = value;
  endtask

  task automatic set_min_times(logic [TimeW-1:0] idle_t, logic [TimeW-1:0] pulse_t);
    in_valid <= 1'b0;
    wait_results_drained();
    write_min_time(CfgIdleTime, idle_t);
    write_min_time(CfgPulseTime, pulse_t);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_refused_requests();
    ips_in_t odd;
    odd = '1;
    odd.op = OpUnused;
    send_item(cmd_item(CmdInit));
    send_item(reg_item(PolRising, 1'b0));
    send_item(reg_item(PolNone, 1'b1));
    send_item(reg_item(PolW'(3), 1'b1));
    send_item(odd);
    send_item(tick_item(TimeMax));
  endtask

  task automatic test_pulse_sequence();
    send_item(reg_item(PolFalling, 1'b1));
    send_item(reg_item(PolRising, 1'b1));
    send_item(cmd_item(CmdInit));
    send_item(tick_item('0));
    send_item(tick_item(TimeW'(1)));
    send_item(cmd_item(CmdStart));
    send_item(tick_item('0));
    send_item(cmd_item(CmdCancel));
    send_item(tick_item(TimeW'(1)));
    send_item(cmd_item(CmdStart));
    send_item(tick_item(TimeMax));
    send_item(tick_item(TimeW'(5)));
    send_item(tick_item(TimeW'(1)));
    send_item(tick_item(TimeW'(3)));
    send_item(reg_item(PolFalling, 1'b1));
    send_item(tick_item(TimeW'(1)));
    send_item(cmd_item(CmdDeinit));
    send_item(tick_item('0));
    send_item(tick_item('0));
  endtask

  task automatic run_pulse_cycle();
    int n;
    send_item(reg_item($urandom_range(0, 1) ? PolFalling : PolRising, 1'b1));
    send_item(cmd_item(CmdInit));
    repeat ($urandom_range(2, 4)) send_item(tick_item(rand_elapsed()));
    send_item(cmd_item(CmdStart));
    send_item(tick_item(rand_elapsed()));
    for (n = 0; n < 16 && ph != PhWait; n++) begin
      if ($urandom_range(0, 15) == 0) send_item(cmd_item(CmdCancel));
      send_item(tick_item(rand_elapsed()));
    end
    if ($urandom_range(0, 1) == 1) begin
      send_item(cmd_item(CmdDeinit));
      repeat (2) send_item(tick_item(rand_elapsed()));
    end
  endtask

  task automatic test_random_traffic();
    int round_idx;
    int target;
    for (round_idx = 0; round_idx < 5; round_idx++) begin
      case (round_idx)
        0: set_min_times('0, '0);
        1: set_min_times(TimeMax, TimeMax);
        default: set_min_times(rand_min_time(), rand_min_time());
      endcase
      idle_on = (round_idx < 4);
      target = items_sent + 100;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) run_pulse_cycle();
        else send_item(noise_item());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rx_hold <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ips_out_t want;
    if (out_valid && out_ready) begin
      if (line_actions_q.size() == 0) begin
        $error("result with no expected transfer: %p", out_data);
        fails++;
      end else begin
        want = line_actions_q.pop_front();
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          fails++;
        end
        if (out_data.line_write !== want.line_write) begin
          $error("line_write: expected %0d, got %0d", want.line_write, out_data.line_write);
          fails++;
        end
        if (out_data.line_level !== want.line_level) begin
          $error("line_level: expected %0d, got %0d", want.line_level, out_data.line_level);
          fails++;
        end
        if (out_data.phase_code !== want.phase_code) begin
          $error("phase_code: expected %0d, got %0d", want.phase_code, out_data.phase_code);
          fails++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    ph = PhWaitReg;
    pol_reg = PolNone;
    drv_seen = 1'b0;
    cmd_latched = CmdCancel;
    on_time = '0;
    off_time = '0;
    min_off = IdleTimeRst;
    min_on = PulseTimeRst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_refused_requests();
    test_pulse_sequence();
    test_random_traffic();
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ips_pkg.sv
hw/rtl/ips_cfg_regs.sv
hw/rtl/ips_core.sv
hw/rtl/interrupt_pulse_sequencer.sv
hw/rtl/ips_checker.sv
verif/tb_top.sv
